>>> rtl/led_matrix_number_frame_generator_macros.svh
// Assertion macros shared by the frame generator modules
`ifndef LED_MATRIX_NUMBER_FRAME_GENERATOR_MACROS_SVH
`define LED_MATRIX_NUMBER_FRAME_GENERATOR_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define LMFG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LMFG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/lmfg_pkg.sv
// Types, constants and helper functions for the LED matrix frame generator
`timescale 1ns / 1ps
`default_nettype none

package lmfg_pkg;

	localparam int MODULES    = 4;
	localparam int MOD_N      = (MODULES < 1) ? 1 : ((MODULES > 8) ? 8 : MODULES);
	localparam int WIN_N      = (MOD_N > 4) ? 4 : MOD_N;
	localparam int NUM_DIGITS = 4;
	localparam int QDEPTH     = 2;
	localparam int PTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W      = $clog2(QDEPTH + 1);
	localparam int VAL_W      = 14;

	// command codes
	localparam logic [1:0] CMD_SHOW  = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_INIT  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_DEADBAND   = 2'd0;
	localparam logic [1:0] CFG_INTENSITY  = 2'd1;
	localparam logic [1:0] CFG_SCAN_LIMIT = 2'd2;

	localparam logic [15:0] DEADBAND_RESET   = 16'd2;
	localparam logic [3:0]  INTENSITY_RESET  = 4'd8;
	localparam logic [2:0]  SCAN_LIMIT_RESET = 3'd7;
	localparam logic [15:0] LAST_SHOWN_RESET = 16'hFFFF;
	localparam logic [15:0] VALUE_MAX        = 16'd9999;

	// driver register addresses
	localparam logic [3:0] REG_DISPLAY_TEST = 4'h0F;
	localparam logic [3:0] REG_SHUTDOWN     = 4'h0C;
	localparam logic [3:0] REG_SCAN_LIMIT   = 4'h0B;
	localparam logic [3:0] REG_INTENSITY    = 4'h0A;
	localparam logic [3:0] REG_DECODE       = 4'h09;

	// frame counter end points and init steps
	localparam logic [3:0] INIT_LAST     = 4'd12;
	localparam logic [3:0] ROW_LAST      = 4'd7;
	localparam logic [3:0] STEP_TEST     = 4'd0;
	localparam logic [3:0] STEP_SHUTDOWN = 4'd1;
	localparam logic [3:0] STEP_SCAN     = 4'd2;
	localparam logic [3:0] STEP_BRIGHT   = 4'd3;
	localparam logic [3:0] STEP_DECODE   = 4'd4;
	localparam logic [3:0] INIT_ROW_BASE = 4'd4;

	// reciprocal constants for /100 and /10
	localparam logic [12:0] DIV100_MUL = 13'd5243;
	localparam logic [7:0]  DIV10_MUL  = 8'd205;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] value;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  reg_addr;
		logic [31:0] window_data;
		logic        last_frame;
	} out_item_t;

	typedef enum logic [1:0] {
		JOB_CLEAR,
		JOB_INIT,
		JOB_NUMBER
	} job_kind_t;

	// digits[0] is the ones digit
	typedef struct packed {
		job_kind_t                   kind;
		logic [NUM_DIGITS-1:0][3:0]  digits;
	} job_t;

	function automatic logic [7:0] glyph_row(input logic [3:0] digit, input logic [2:0] row);
		logic [63:0] g;
		logic [5:0]  base;
		case (digit)
			4'd0: g = 64'h3C666E7666663C00;
			4'd1: g = 64'h183818181818_7E00;
			4'd2: g = 64'h3C66061C30607E00;
			4'd3: g = 64'h3C66061C06663C00;
			4'd4: g = 64'h0C1C3C6C7E0C0C00;
			4'd5: g = 64'h7E607C0606663C00;
			4'd6: g = 64'h3C607C6666663C00;
			4'd7: g = 64'h7E060C1830303000;
			4'd8: g = 64'h3C66663C66663C00;
			4'd9: g = 64'h3C66663E060C3800;
			default: g = '0;
		endcase
		base = {3'd7 - row, 3'b000};
		return g[base +: 8];
	endfunction

	function automatic logic [31:0] same_window(input logic [7:0] b);
		logic [31:0] w;
		w = '0;
		for (int i = 0; i < 4; i++) begin
			if (i < WIN_N) begin
				w[8*(3-i) +: 8] = b;
			end
		end
		return w;
	endfunction

endpackage

`default_nettype wire

>>> rtl/lmfg_queue.sv
// Short job queue between the command front end and the frame sequencer
`timescale 1ns / 1ps
`default_nettype none
`include "led_matrix_number_frame_generator_macros.svh"

module lmfg_queue
	import lmfg_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  job_t      push_job,
	output logic      full,
	output logic      head_valid,
	output job_t      head_job,
	input  wire logic pop
);

	job_t             entries_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = entries_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	`LMFG_ASSERT_NOW(a_pop_nonempty, pop, count_q != '0, "pop from empty job queue")

endmodule

`default_nettype wire

>>> rtl/lmfg_front.sv
// Command front end: deadband filter, clamp and decimal split into jobs
`timescale 1ns / 1ps
`default_nettype none
`include "led_matrix_number_frame_generator_macros.svh"

module lmfg_front
	import lmfg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [15:0] deadband,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  in_item_t         in_data,
	output logic             push,
	output job_t             push_job,
	input  wire logic        q_full
);

	logic             adv;
	logic             accept;
	logic [15:0]      diff;
	logic             show_pass;
	logic             s1_valid_d;
	job_kind_t        s1_kind_d;
	logic [VAL_W-1:0] clamped;
	logic [25:0]      prod;
	logic [13:0]      lo_full;

	logic [15:0]      last_shown_q;
	logic             s1_valid_s1;
	logic             s2_valid_s2;
	logic             s3_valid_s3;
	job_kind_t        kind_s1;
	job_kind_t        kind_s2;
	job_kind_t        kind_s3;
	logic [VAL_W-1:0] n_s1;
	logic [VAL_W-1:0] n_s2;
	logic [6:0]       q_s2;
	logic [6:0]       hi_s3;
	logic [6:0]       lo_s3;

	assign adv      = !(s3_valid_s3 && q_full);
	assign in_stall = !adv;
	assign accept   = in_valid && adv;

	assign diff = (in_data.value > last_shown_q) ? in_data.value - last_shown_q
	                                             : last_shown_q - in_data.value;
	assign show_pass = (in_data.value != last_shown_q) && (diff >= deadband);
	assign clamped   = (in_data.value > VALUE_MAX) ? VAL_W'(VALUE_MAX)
	                                               : in_data.value[VAL_W-1:0];

	always_comb begin
		s1_valid_d = 1'b0;
		s1_kind_d  = JOB_CLEAR;
		case (in_data.cmd)
			CMD_SHOW: begin
				s1_valid_d = show_pass;
				s1_kind_d  = (in_data.value == '0) ? JOB_CLEAR : JOB_NUMBER;
			end
			CMD_CLEAR: begin
				s1_valid_d = 1'b1;
			end
			CMD_INIT: begin
				s1_valid_d = 1'b1;
				s1_kind_d  = JOB_INIT;
			end
			default: begin
				s1_valid_d = 1'b0;
			end
		endcase
	end

	// n / 100 by reciprocal, exact for n <= 9999
	assign prod    = 26'(n_s1) * 26'(DIV100_MUL);
	assign lo_full = n_s2 - ((14'(q_s2) << 6) + (14'(q_s2) << 5) + (14'(q_s2) << 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_shown_q <= LAST_SHOWN_RESET;
			s1_valid_s1  <= 1'b0;
			s2_valid_s2  <= 1'b0;
			s3_valid_s3  <= 1'b0;
		end else begin
			if (adv) begin
				s1_valid_s1 <= accept && s1_valid_d;
				s2_valid_s2 <= s1_valid_s1;
				s3_valid_s3 <= s2_valid_s2;
			end
			if (accept && (in_data.cmd == CMD_SHOW) && show_pass) begin
				last_shown_q <= in_data.value;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= s1_kind_d;
			n_s1    <= clamped;
			kind_s2 <= kind_s1;
			n_s2    <= n_s1;
			q_s2    <= prod[25:19];
			kind_s3 <= kind_s2;
			hi_s3   <= q_s2;
			lo_s3   <= lo_full[6:0];
		end
	end

	// two decimal digits of a value below 100
	function automatic logic [7:0] split2(input logic [6:0] x);
		logic [14:0] p;
		logic [3:0]  tens;
		logic [6:0]  ones;
		p    = 15'(x) * 15'(DIV10_MUL);
		tens = p[14:11];
		ones = x - ((7'(tens) << 3) + (7'(tens) << 1));
		return {tens, ones[3:0]};
	endfunction

	assign push                 = s3_valid_s3 && !q_full;
	assign push_job.kind        = kind_s3;
	assign push_job.digits[3:2] = split2(hi_s3);
	assign push_job.digits[1:0] = split2(lo_s3);

	`LMFG_ASSERT_NEXT(a_repeat_suppressed,
		accept && (in_data.cmd == CMD_SHOW) && (in_data.value == last_shown_q),
		!s1_valid_s1, "repeated value not suppressed")

endmodule

`default_nettype wire

>>> rtl/lmfg_back.sv
// Frame sequencer: expands one job into latch-window frames
`timescale 1ns / 1ps
`default_nettype none
`include "led_matrix_number_frame_generator_macros.svh"

module lmfg_back
	import lmfg_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [3:0] intensity,
	input  wire logic [2:0] scan_limit,
	input  wire logic       head_valid,
	input  job_t            head_job,
	output logic            pop,
	output logic            out_valid,
	input  wire logic       out_stall,
	output out_item_t       out_data
);

	logic       load;
	logic       last;
	logic [3:0] end_cnt;
	out_item_t  frame_d;
	logic [3:0] cnt_q;
	logic       out_valid_q;
	out_item_t  out_data_q;

	assign end_cnt = (head_job.kind == JOB_INIT) ? INIT_LAST : ROW_LAST;
	assign last    = (cnt_q == end_cnt);
	assign load    = head_valid && (!out_valid_q || !out_stall);
	assign pop     = load && last;

	always_comb begin
		frame_d.reg_addr    = cnt_q + 4'd1;
		frame_d.window_data = '0;
		frame_d.last_frame  = last;
		case (head_job.kind)
			JOB_INIT: begin
				case (cnt_q)
					STEP_TEST: begin
						frame_d.reg_addr = REG_DISPLAY_TEST;
					end
					STEP_SHUTDOWN: begin
						frame_d.reg_addr    = REG_SHUTDOWN;
						frame_d.window_data = same_window(8'h01);
					end
					STEP_SCAN: begin
						frame_d.reg_addr    = REG_SCAN_LIMIT;
						frame_d.window_data = same_window({5'b0, scan_limit});
					end
					STEP_BRIGHT: begin
						frame_d.reg_addr    = REG_INTENSITY;
						frame_d.window_data = same_window({4'b0, intensity});
					end
					STEP_DECODE: begin
						frame_d.reg_addr = REG_DECODE;
					end
					default: begin
						frame_d.reg_addr = cnt_q - INIT_ROW_BASE;
					end
				endcase
			end
			JOB_NUMBER: begin
				for (int i = 0; i < 4; i++) begin
					if (i < MOD_N) begin
						if ((MOD_N - 1 - i) < NUM_DIGITS) begin
							frame_d.window_data[8*(3-i) +: 8] =
								glyph_row(head_job.digits[2'(MOD_N - 1 - i)], cnt_q[2:0]);
						end else begin
							frame_d.window_data[8*(3-i) +: 8] = glyph_row(4'd0, cnt_q[2:0]);
						end
					end
				end
			end
			default: begin
				frame_d.window_data = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				cnt_q <= last ? '0 : cnt_q + 4'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= frame_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`LMFG_ASSERT_NOW(a_busy_has_job, cnt_q != '0, head_valid,
		"frame counter running without a queued job")
	`LMFG_ASSERT_NOW(a_row_cnt_range, head_valid && (head_job.kind != JOB_INIT),
		cnt_q <= ROW_LAST, "row frame counter out of range")

endmodule

`default_nettype wire

>>> rtl/led_matrix_number_frame_generator.sv
// Top level: configuration registers, command front end, job queue, frame sequencer
// Path of a command: front-end stages s1, s2, s3, then the job queue, then the output register to out_valid.
// Throughput: one frame per cycle while out_stall is low; 8 frames per clear or number, 13 per init,
// set by the frame sequencer; commands are accepted every cycle while the job queue has room.
// Reset: asynchronous, active low; restores the register defaults and the last value 65535.
`timescale 1ns / 1ps
`default_nettype none

module led_matrix_number_frame_generator
	import lmfg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output out_item_t        out_data
);

	logic [15:0] deadband_q;
	logic [3:0]  intensity_q;
	logic [2:0]  scan_limit_q;
	logic        push;
	job_t        push_job;
	logic        q_full;
	logic        head_valid;
	job_t        head_job;
	logic        pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q   <= DEADBAND_RESET;
			intensity_q  <= INTENSITY_RESET;
			scan_limit_q <= SCAN_LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEADBAND:   deadband_q   <= cfg_data;
				CFG_INTENSITY:  intensity_q  <= cfg_data[3:0];
				CFG_SCAN_LIMIT: scan_limit_q <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	lmfg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.deadband (deadband_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.push     (push),
		.push_job (push_job),
		.q_full   (q_full)
	);

	lmfg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop)
	);

	lmfg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.intensity  (intensity_q),
		.scan_limit (scan_limit_q),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for the LED matrix number frame generator
`timescale 1ns / 1ps

module testbench;
	import lmfg_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 16;

	localparam logic [63:0] FONT_ROWS [0:9] = '{
		64'h3C666E7666663C00, 64'h1838181818187E00, 64'h3C66061C30607E00,
		64'h3C66061C06663C00, 64'h0C1C3C6C7E0C0C00, 64'h7E607C0606663C00,
		64'h3C607C6666663C00, 64'h7E060C1830303000, 64'h3C66663C66663C00,
		64'h3C66663E060C3800
	};

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_data;

	logic [15:0] db_setting;
	logic [3:0]  bright_setting;
	logic [2:0]  scan_setting;
	logic [15:0] shown_value;

	out_item_t frames_due[$];
	bit        fail_seen;
	int        send_idle_pct;
	int        recv_stall_pct;

	led_matrix_number_frame_generator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [31:0] pack_modules(input logic [7:0][7:0] mods);
		logic [31:0] w;
		w = '0;
		for (int i = 0; i < WIN_N; i++) begin
			w[31-8*i -: 8] = mods[i];
		end
		return w;
	endfunction

	function automatic out_item_t make_frame(input logic [3:0] addr, input logic [31:0] win);
		out_item_t f;
		f.reg_addr = addr;
		f.window_data = win;
		f.last_frame = 1'b0;
		return f;
	endfunction

	function automatic void expect_blank_rows();
		for (int r = 1; r <= 8; r++) begin
			frames_due.push_back(make_frame(4'(r), 32'd0));
		end
	endfunction

	function automatic void predict_frames(input logic [1:0] c, input logic [15:0] v);
		int         prior;
		int         num;
		logic [15:0] gap;
		logic [7:0][3:0] digit;
		logic [7:0][7:0] mods;
		out_item_t  f;
		prior = frames_due.size();
		case (c)
			CMD_INIT: begin
				frames_due.push_back(make_frame(REG_DISPLAY_TEST, pack_modules({8{8'h00}})));
				frames_due.push_back(make_frame(REG_SHUTDOWN, pack_modules({8{8'h01}})));
				frames_due.push_back(make_frame(REG_SCAN_LIMIT,
					pack_modules({8{{5'd0, scan_setting}}})));
				frames_due.push_back(make_frame(REG_INTENSITY,
					pack_modules({8{{4'd0, bright_setting}}})));
				frames_due.push_back(make_frame(REG_DECODE, pack_modules({8{8'h00}})));
				expect_blank_rows();
			end
			CMD_CLEAR: begin
				expect_blank_rows();
			end
			CMD_SHOW: begin
				gap = (v > shown_value) ? v - shown_value : shown_value - v;
				if (v != shown_value && gap >= db_setting) begin
					shown_value = v;
					if (v == 16'd0) begin
						expect_blank_rows();
					end else begin
						num = (v > VALUE_MAX) ? int'(VALUE_MAX) : int'(v);
						for (int i = 0; i < 8; i++) begin
							digit[i] = 4'(num % 10);
							num = num / 10;
						end
						for (int row = 0; row < 8; row++) begin
							mods = '0;
							for (int i = 0; i < MOD_N; i++) begin
								mods[i] = FONT_ROWS[digit[MOD_N-1-i]][63-8*row -: 8];
							end
							frames_due.push_back(make_frame(4'(row + 1), pack_modules(mods)));
						end
					end
				end
			end
			default: ;
		endcase
		if (frames_due.size() > prior) begin
			f = frames_due.pop_back();
			f.last_frame = 1'b1;
			frames_due.push_back(f);
		end
	endfunction

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin : frame_check
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (frames_due.size() == 0) begin
				$error("unexpected frame: reg_addr %0h window_data %08h last_frame %0b",
					out_data.reg_addr, out_data.window_data, out_data.last_frame);
				fail_seen = 1'b1;
			end else begin
				want = frames_due.pop_front();
				if (out_data.reg_addr !== want.reg_addr) begin
					$error("reg_addr: expected %0h, got %0h", want.reg_addr, out_data.reg_addr);
					fail_seen = 1'b1;
				end
				if (out_data.window_data !== want.window_data) begin
					$error("window_data: expected %08h, got %08h",
						want.window_data, out_data.window_data);
					fail_seen = 1'b1;
				end
				if (out_data.last_frame !== want.last_frame) begin
					$error("last_frame: expected %0b, got %0b",
						want.last_frame, out_data.last_frame);
					fail_seen = 1'b1;
				end
			end
		end
	end

	task automatic send_cmd(input logic [1:0] c, input logic [15:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data.cmd <= c;
		in_data.value <= v;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		predict_frames(c, v);
	endtask

	// show commands that are suppressed give no frames, so allow them to pass through too
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (frames_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input logic [15:0] db, input logic [3:0] bright,
		input logic [2:0] scan);
		cfg_we <= 1'b1;
		cfg_index <= CFG_DEADBAND;
		cfg_data <= db;
		@(posedge clk);
		cfg_index <= CFG_INTENSITY;
		cfg_data <= {12'd0, bright};
		@(posedge clk);
		cfg_index <= CFG_SCAN_LIMIT;
		cfg_data <= {13'd0, scan};
		@(posedge clk);
		cfg_we <= 1'b0;
		db_setting = db;
		bright_setting = bright;
		scan_setting = scan;
	endtask

	task automatic check_init_and_clear();
		send_cmd(CMD_INIT, 16'h0000);
		send_cmd(CMD_CLEAR, 16'hFFFF);
		send_cmd(CMD_UNUSED, 16'hFFFF);
	endtask

	task automatic check_number_edges();
		send_cmd(CMD_SHOW, 16'hFFFF);
		send_cmd(CMD_SHOW, 16'hFFFE);
		send_cmd(CMD_SHOW, 16'd0);
		send_cmd(CMD_SHOW, 16'd0);
		send_cmd(CMD_SHOW, 16'd1);
		send_cmd(CMD_SHOW, 16'd2);
		send_cmd(CMD_SHOW, 16'd10000);
		send_cmd(CMD_SHOW, 16'd9999);
		send_cmd(CMD_SHOW, 16'd1234);
		send_cmd(CMD_UNUSED, 16'd0);
		send_cmd(CMD_SHOW, 16'd5678);
	endtask

	task automatic check_register_extremes();
		wait_idle();
		program_regs(16'd0, 4'd15, 3'd0);
		send_cmd(CMD_INIT, 16'h5555);
		send_cmd(CMD_SHOW, 16'd5678);
		send_cmd(CMD_SHOW, 16'd5679);
		send_cmd(CMD_SHOW, 16'd0);
		wait_idle();
		program_regs(16'hFFFF, 4'd0, 3'd7);
		send_cmd(CMD_INIT, 16'hAAAA);
		send_cmd(CMD_SHOW, 16'hFFFF);
		send_cmd(CMD_SHOW, 16'd1);
		wait_idle();
	endtask

	function automatic logic [15:0] pick_deadband();
		case ($urandom_range(5))
			0: return 16'd0;
			1: return 16'd1;
			2: return DEADBAND_RESET;
			3: return 16'hFFFF;
			default: return 16'($urandom_range(3, 40));
		endcase
	endfunction

	function automatic logic [15:0] pick_value();
		case ($urandom_range(9))
			0: return 16'd0;
			1: return 16'hFFFF;
			2, 3: return 16'($urandom_range(9999));
			4, 5: return 16'($urandom);
			6: return shown_value + 16'($urandom_range(6));
			7: return shown_value - 16'($urandom_range(6));
			8: return shown_value + db_setting;
			default: return shown_value - db_setting - 16'($urandom_range(1));
		endcase
	endfunction

	task automatic check_random_traffic(input int idle_pct, input int stall_pct, input int count);
		int sent;
		int pick;
		logic [1:0] c;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int half = 0; half < 2; half++) begin
			wait_idle();
			program_regs(pick_deadband(), 4'($urandom), 3'($urandom));
			sent = 0;
			while (sent < count / 2) begin
				pick = $urandom_range(99);
				if (pick < 72) begin
					c = CMD_SHOW;
				end else if (pick < 84) begin
					c = CMD_CLEAR;
				end else if (pick < 94) begin
					c = CMD_INIT;
				end else begin
					c = CMD_UNUSED;
				end
				send_cmd(c, pick_value());
				if (c != CMD_UNUSED) begin
					sent++;
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_DEADBAND;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		fail_seen = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		db_setting = DEADBAND_RESET;
		bright_setting = INTENSITY_RESET;
		scan_setting = SCAN_LIMIT_RESET;
		shown_value = LAST_SHOWN_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		check_init_and_clear();
		check_number_edges();
		check_register_extremes();
		check_random_traffic(0, 0, 64);
		check_random_traffic(86, 0, 62);
		check_random_traffic(0, 86, 62);
		check_random_traffic(38, 38, 62);

		wait_idle();
		repeat (20) @(posedge clk);
		if (!fail_seen && frames_due.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
